/* design/sql_token_lexer_defines.svh */
// ---------------------------------------------------------------------------
// SQL token lexer - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SQL_TOKEN_LEXER_DEFINES_SVH
`define SQL_TOKEN_LEXER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SQLT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SQLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/sqlt_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SQL token lexer - package
// Beat types, token kinds, keyword table and small shared helpers.
// ---------------------------------------------------------------------------
package sqlt_pkg;

	localparam int unsigned DEF_MAX_INPUT_BYTES   = 65536;
	localparam int unsigned DEF_KEYWORD_MAX_CHARS = 8;

	// Characters kept for keyword matching; the longest keyword has 8.
	localparam int unsigned KW_CHARS  = 8;
	localparam int unsigned KW_IDX_W  = $clog2(KW_CHARS);
	localparam int unsigned KW_COUNT  = 17;
	localparam int unsigned WLEN_W    = 5;

	// Token slots per input beat: byte close/continue, punctuation, end close, END.
	localparam int unsigned SLOTS     = 4;
	localparam int unsigned SLOT_W    = $clog2(SLOTS);
	localparam int unsigned FIFO_DEPTH = 4;

	localparam logic [5:0] K_END    = 6'd0;
	localparam logic [5:0] K_IDENT  = 6'd1;
	localparam logic [5:0] K_NUMBER = 6'd2;
	localparam logic [5:0] K_STRING = 6'd3;
	localparam logic [5:0] K_KW0    = 6'd4;
	localparam logic [5:0] K_STAR   = 6'd21;
	localparam logic [5:0] K_COMMA  = 6'd22;
	localparam logic [5:0] K_LPAREN = 6'd23;
	localparam logic [5:0] K_RPAREN = 6'd24;
	localparam logic [5:0] K_DOT    = 6'd25;
	localparam logic [5:0] K_SEMI   = 6'd26;
	localparam logic [5:0] K_EQ     = 6'd27;
	localparam logic [5:0] K_NEQ    = 6'd28;
	localparam logic [5:0] K_LT     = 6'd29;
	localparam logic [5:0] K_LTE    = 6'd30;
	localparam logic [5:0] K_GT     = 6'd31;
	localparam logic [5:0] K_GTE    = 6'd32;

	// Keyword text, first character in the top byte, zero padded.
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		{"SELECT", 16'h0000}, {"FROM", 32'h0000_0000}, {"WHERE", 24'h00_0000},
		{"JOIN", 32'h0000_0000}, {"ON", 48'h0000_0000_0000},
		{"INSERT", 16'h0000}, {"INTO", 32'h0000_0000}, {"VALUES", 16'h0000},
		{"DELETE", 16'h0000}, {"CREATE", 16'h0000}, {"TABLE", 24'h00_0000},
		{"BEGIN", 24'h00_0000}, {"COMMIT", 16'h0000}, {"ROLLBACK"},
		{"EXPLAIN", 8'h00}, {"AND", 40'h00_0000_0000}, {"OR", 48'h0000_0000_0000}
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd6, 4'd4, 4'd5, 4'd4, 4'd2, 4'd6, 4'd4, 4'd6, 4'd6,
		4'd6, 4'd5, 4'd5, 4'd6, 4'd8, 4'd7, 4'd3, 4'd2
	};

	typedef struct packed {
		logic [7:0] char_code;
		logic       has_char;
		logic       is_last;
	} lex_in_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] text_start;
		logic [15:0] text_length;
		logic        position_overflow;
		logic        last_result;
	} lex_out_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
	} tok_t;

	typedef struct packed {
		tok_t [SLOTS-1:0] tok;
		logic [SLOTS-1:0] valid;
		logic             ovf;
	} tok_group_t;

	function automatic logic [15:0] grow(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// Keyword lookup over the stored prefix; only the first len bytes count.
	function automatic logic [5:0] word_kind(input logic [63:0] prefix,
	                                         input logic [WLEN_W-1:0] len,
	                                         input logic too_long);
		logic [5:0]  kind;
		logic [63:0] mask;
		kind = K_IDENT;
		mask = '0;
		if (!too_long) begin
			for (int k = 0; k < KW_COUNT; k++) begin
				mask = ~({64{1'b1}} >> {KW_LEN[k], 3'b000});
				if (len == WLEN_W'(KW_LEN[k]) && ((prefix ^ KW_TEXT[k]) & mask) == 64'd0)
					kind = K_KW0 + 6'(k);
			end
		end
		return kind;
	endfunction

endpackage

/* design/sql_token_lexer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SQL token lexer - top level
// Byte stream in, (kind, start, length) tokens out, with a token group queue
// between the lexing front end and the token back end.
// ---------------------------------------------------------------------------
//  channel   | beat                  | handshake
//  ----------+-----------------------+-------------------------------
//  byte      | lex_in_t, one byte    | byte_valid / byte_stall
//  token     | lex_out_t, one token  | token_valid / token_stall
//
//  One byte beat is taken every cycle while the four-entry group queue has room.
//  A beat that yields k tokens (k up to 3) sends them one by one on the token port;
//  the back end sends one token per cycle from the queue head while not stalled.
//  A token passes from its byte beat through the group queue to the output register.
//  Asynchronous reset returns the lexer to idle at offset 0; no clearing pass.
//  Token stall backs up into the queue; byte stall rises only when it is full.
// ---------------------------------------------------------------------------
module sql_token_lexer #(
	parameter int unsigned MAX_INPUT_BYTES   = sqlt_pkg::DEF_MAX_INPUT_BYTES,
	parameter int unsigned KEYWORD_MAX_CHARS = sqlt_pkg::DEF_KEYWORD_MAX_CHARS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  sqlt_pkg::lex_in_t  byte_item,
	output logic               token_valid,
	input  logic               token_stall,
	output sqlt_pkg::lex_out_t token_item
);
	import sqlt_pkg::*;

	logic       q_full;
	logic       push;
	tok_group_t push_group;
	logic       pop;
	logic       head_valid;
	tok_group_t head_group;

	sqlt_front #(
		.MAX_INPUT_BYTES   (MAX_INPUT_BYTES),
		.KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.q_full     (q_full),
		.push       (push),
		.push_group (push_group)
	);

	sqlt_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_group (head_group)
	);

	sqlt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_group  (head_group),
		.pop         (pop),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_item  (token_item)
	);

endmodule

/* design/sqlt_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SQL token lexer - front end
// Takes one byte beat per cycle while the queue is not full, advances the lexer
// state and groups the tokens that the beat closes into one queue entry.
// ---------------------------------------------------------------------------
module sqlt_front #(
	parameter int unsigned MAX_INPUT_BYTES   = sqlt_pkg::DEF_MAX_INPUT_BYTES,
	parameter int unsigned KEYWORD_MAX_CHARS = sqlt_pkg::DEF_KEYWORD_MAX_CHARS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  sqlt_pkg::lex_in_t    byte_item,
	input  logic                 q_full,
	output logic                 push,
	output sqlt_pkg::tok_group_t push_group
);
	import sqlt_pkg::*;

	localparam int unsigned POS_LIMIT = (MAX_INPUT_BYTES - 1 > 65535) ? 65535
	                                                                  : MAX_INPUT_BYTES - 1;
	localparam int unsigned POS_W = $clog2(POS_LIMIT + 2);
	localparam int unsigned WL_W  = $clog2(KEYWORD_MAX_CHARS + 2);

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_WORD = 3'd1;
	localparam logic [2:0] M_NUM  = 3'd2;
	localparam logic [2:0] M_STR  = 3'd3;
	localparam logic [2:0] M_GT   = 3'd4;
	localparam logic [2:0] M_LT   = 3'd5;
	localparam logic [2:0] M_BANG = 3'd6;

	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	logic [2:0]                   mode_q, mode_b;
	logic [POS_W-1:0]             pos_q, pos_n;
	logic [15:0]                  start_q, start_b;
	logic [15:0]                  run_q, run_b;
	logic [0:KW_CHARS-1][7:0]     prefix_q, prefix_b;
	logic [WL_W-1:0]              wlen_q, wlen_b;
	logic                         ovf_q, ovf_n;

	logic [7:0]  c;
	logic        is_upper, is_lower, is_letter, is_digit, is_wordch;
	logic [7:0]  up_c;
	logic [15:0] off;
	logic        taken;
	tok_t        tok0, tok1;
	logic        tok0_v, tok0_word, tok1_v;
	logic [5:0]  kw;
	logic [15:0] end_pos;
	logic        accept;

	assign c         = byte_item.char_code;
	assign is_upper  = (c >= 8'h41) && (c <= 8'h5A);
	assign is_lower  = (c >= 8'h61) && (c <= 8'h7A);
	assign is_letter = is_upper || is_lower;
	assign is_digit  = (c >= 8'h30) && (c <= 8'h39);
	assign is_wordch = is_letter || is_digit || (c == CH_UNDER);
	assign up_c      = is_lower ? c - 8'd32 : c;

	assign accept     = byte_valid && !q_full;
	assign byte_stall = q_full;

	// Byte step: continue or close the pending token, then start a new one.
	always_comb begin
		off       = '0;
		pos_n     = pos_q;
		ovf_n     = ovf_q;
		mode_b    = mode_q;
		start_b   = start_q;
		run_b     = run_q;
		prefix_b  = prefix_q;
		wlen_b    = wlen_q;
		taken     = 1'b0;
		tok0      = '0;
		tok0_v    = 1'b0;
		tok0_word = 1'b0;
		tok1      = '0;
		tok1_v    = 1'b0;
		if (byte_item.has_char) begin
			if (pos_q <= POS_W'(POS_LIMIT)) begin
				off   = 16'(pos_q);
				pos_n = pos_q + 1'b1;
			end else begin
				off   = 16'(POS_LIMIT);
				ovf_n = 1'b1;
			end
			unique case (mode_q) inside
				M_WORD: begin
					if (is_wordch) begin
						if (wlen_q < WL_W'(KW_CHARS))
							prefix_b[wlen_q[KW_IDX_W-1:0]] = up_c;
						if (wlen_q <= WL_W'(KEYWORD_MAX_CHARS))
							wlen_b = wlen_q + 1'b1;
						run_b = grow(run_q);
						taken = 1'b1;
					end
				end
				M_NUM: begin
					if (is_digit) begin
						run_b = grow(run_q);
						taken = 1'b1;
					end
				end
				M_STR: begin
					taken = 1'b1;
					if (c == CH_QUOTE) begin
						tok0   = '{K_STRING, start_q, run_q};
						tok0_v = 1'b1;
						mode_b = M_IDLE;
					end else begin
						run_b = grow(run_q);
					end
				end
				M_GT, M_LT, M_BANG: begin
					if (c == CH_EQ) begin
						tok0.kind  = (mode_q == M_GT) ? K_GTE : ((mode_q == M_LT) ? K_LTE : K_NEQ);
						tok0.start = start_q;
						tok0.len   = 16'd2;
						tok0_v     = 1'b1;
						mode_b     = M_IDLE;
						taken      = 1'b1;
					end
				end
				default: ;
			endcase
			if (!taken) begin
				// Close what is pending; a lone bang closes to nothing.
				unique case (mode_q)
					M_WORD: begin
						tok0      = '{K_IDENT, start_q, run_q};
						tok0_v    = 1'b1;
						tok0_word = 1'b1;
					end
					M_NUM: begin
						tok0   = '{K_NUMBER, start_q, run_q};
						tok0_v = 1'b1;
					end
					M_GT: begin
						tok0   = '{K_GT, start_q, 16'd1};
						tok0_v = 1'b1;
					end
					M_LT: begin
						tok0   = '{K_LT, start_q, 16'd1};
						tok0_v = 1'b1;
					end
					default: ;
				endcase
				mode_b  = M_IDLE;
				start_b = off;
				run_b   = 16'd1;
				if (is_letter || c == CH_UNDER) begin
					mode_b      = M_WORD;
					prefix_b[0] = up_c;
					wlen_b      = WL_W'(1);
				end else if (is_digit) begin
					mode_b = M_NUM;
				end else begin
					tok1.start = off;
					tok1.len   = 16'd1;
					unique case (c)
						CH_QUOTE: begin
							mode_b  = M_STR;
							start_b = (off < 16'(POS_LIMIT)) ? off + 16'd1 : 16'(POS_LIMIT);
							run_b   = 16'd0;
						end
						CH_STAR:   begin tok1.kind = K_STAR;   tok1_v = 1'b1; end
						CH_COMMA:  begin tok1.kind = K_COMMA;  tok1_v = 1'b1; end
						CH_LPAREN: begin tok1.kind = K_LPAREN; tok1_v = 1'b1; end
						CH_RPAREN: begin tok1.kind = K_RPAREN; tok1_v = 1'b1; end
						CH_DOT:    begin tok1.kind = K_DOT;    tok1_v = 1'b1; end
						CH_SEMI:   begin tok1.kind = K_SEMI;   tok1_v = 1'b1; end
						CH_EQ:     begin tok1.kind = K_EQ;     tok1_v = 1'b1; end
						CH_GT:     mode_b = M_GT;
						CH_LT:     mode_b = M_LT;
						CH_BANG:   mode_b = M_BANG;
						default: ;
					endcase
				end
			end
		end
	end

	// A word closed by this byte keeps its prefix unchanged, so one lookup on
	// the post-byte prefix serves both the byte close and the end close.
	assign kw = word_kind(prefix_b, WLEN_W'(wlen_b), wlen_b > WL_W'(KEYWORD_MAX_CHARS));
	assign end_pos = (pos_n > POS_W'(POS_LIMIT)) ? 16'(POS_LIMIT) : 16'(pos_n);

	always_comb begin
		push_group          = '0;
		push_group.ovf      = ovf_n;
		push_group.tok[0]   = tok0;
		if (tok0_word)
			push_group.tok[0].kind = kw;
		push_group.valid[0] = tok0_v;
		push_group.tok[1]   = tok1;
		push_group.valid[1] = tok1_v;
		if (byte_item.is_last) begin
			unique case (mode_b)
				M_WORD: begin
					push_group.tok[2]   = '{kw, start_b, run_b};
					push_group.valid[2] = 1'b1;
				end
				M_NUM: begin
					push_group.tok[2]   = '{K_NUMBER, start_b, run_b};
					push_group.valid[2] = 1'b1;
				end
				M_STR: begin
					push_group.tok[2]   = '{K_STRING, start_b, run_b};
					push_group.valid[2] = 1'b1;
				end
				M_GT: begin
					push_group.tok[2]   = '{K_GT, start_b, 16'd1};
					push_group.valid[2] = 1'b1;
				end
				M_LT: begin
					push_group.tok[2]   = '{K_LT, start_b, 16'd1};
					push_group.valid[2] = 1'b1;
				end
				default: ;
			endcase
			push_group.tok[3]   = '{K_END, end_pos, 16'd0};
			push_group.valid[3] = 1'b1;
		end
	end

	assign push = accept && (push_group.valid != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			run_q   <= '0;
			wlen_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (byte_item.is_last) begin
				// End of text: back to the reset state for the next one.
				mode_q  <= M_IDLE;
				pos_q   <= '0;
				start_q <= '0;
				run_q   <= '0;
				wlen_q  <= '0;
				ovf_q   <= 1'b0;
			end else begin
				mode_q  <= mode_b;
				pos_q   <= pos_n;
				start_q <= start_b;
				run_q   <= run_b;
				wlen_q  <= wlen_b;
				ovf_q   <= ovf_n;
			end
		end
	end

	// Prefix bytes past the word length are never compared.
	always_ff @(posedge clk) begin
		if (accept)
			prefix_q <= prefix_b;
	end

endmodule

/* design/sqlt_fifo.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SQL token lexer - token group queue
// Short register queue of token groups between front end and back end.
// ---------------------------------------------------------------------------
module sqlt_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sqlt_pkg::tok_group_t push_group,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output sqlt_pkg::tok_group_t head_group
);
	import sqlt_pkg::*;

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	tok_group_t       entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_group = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_group;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* design/sqlt_back.sv */
`timescale 1ns / 1ps
`include "sql_token_lexer_defines.svh"
// ---------------------------------------------------------------------------
// SQL token lexer - back end
// Unpacks the head token group one token per beat into the output register.
// ---------------------------------------------------------------------------
module sqlt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  sqlt_pkg::tok_group_t head_group,
	output logic                 pop,
	output logic                 token_valid,
	input  logic                 token_stall,
	output sqlt_pkg::lex_out_t   token_item
);
	import sqlt_pkg::*;

	logic [SLOTS-1:0]  sent_q;
	logic [SLOTS-1:0]  pending, rest;
	logic [SLOT_W-1:0] pick;
	logic              found;
	logic              final_tok;
	logic              load;
	logic              out_valid_q;
	lex_out_t          out_q;

	// Lowest slot not yet sent goes next.
	always_comb begin
		pending = head_group.valid & ~sent_q;
		pick    = '0;
		found   = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (pending[i] && !found) begin
				pick  = SLOT_W'(i);
				found = 1'b1;
			end
		end
		rest      = pending & ~(SLOTS'(1) << pick);
		final_tok = (rest == '0);
	end

	assign load = head_valid && (!out_valid_q || !token_stall);
	assign pop  = load && final_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sent_q      <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (!token_stall)
				out_valid_q <= 1'b0;
			if (load)
				sent_q <= final_tok ? '0 : (sent_q | (SLOTS'(1) << pick));
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.token_kind        <= head_group.tok[pick].kind;
			out_q.text_start        <= head_group.tok[pick].start;
			out_q.text_length       <= head_group.tok[pick].len;
			out_q.position_overflow <= head_group.ovf;
			out_q.last_result       <= final_tok;
		end
	end

	assign token_valid = out_valid_q;
	assign token_item  = out_q;

	`SQLT_ASSERT_SAME(a_pop_has_head, pop, head_valid, "pop with no queued group")
	`SQLT_ASSERT_SAME(a_head_pending, head_valid, (head_group.valid & ~sent_q) != '0, "queued group has no token left")
	`SQLT_ASSERT_NEXT(a_pop_clears_sent, pop, sent_q == '0, "sent mask kept after pop")

endmodule

/* bench/lexer_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SQL token lexer - channel checker
// Watches the byte and token channels, tracks the lexer state on every
// accepted byte beat, and compares each accepted token field by field with
// the oldest token still due. Reports the failure count to the bench top.
// ---------------------------------------------------------------------------
module lexer_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic               byte_stall,
	input  sqlt_pkg::lex_in_t  byte_item,
	input  logic               token_valid,
	input  logic               token_stall,
	input  sqlt_pkg::lex_out_t token_item,
	output int                 fail_count,
	output int                 pending,
	output int                 tokens_checked
);
	import sqlt_pkg::*;

	localparam int unsigned POS_LIMIT =
		(DEF_MAX_INPUT_BYTES - 1 > 65535) ? 65535 : DEF_MAX_INPUT_BYTES - 1;
	localparam int unsigned WORD_KEEP = DEF_KEYWORD_MAX_CHARS;

	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_WORD, SCAN_NUM, SCAN_STR, SCAN_GT, SCAN_LT, SCAN_BANG
	} scan_mode_t;

	scan_mode_t  mode;
	logic [16:0] next_pos;
	logic [15:0] tok_start;
	logic [15:0] run_len;
	logic [63:0] prefix;
	logic [3:0]  wlen;
	logic        ovf;

	lex_out_t step_toks[$];
	lex_out_t tokens_due[$];
	lex_out_t want;
	int       fails = 0;
	int       checked = 0;

	function automatic bit is_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [7:0] upper(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	task automatic clear_scan();
		mode = SCAN_IDLE;
		next_pos = '0;
		tok_start = '0;
		run_len = '0;
		prefix = '0;
		wlen = '0;
		ovf = 1'b0;
	endtask

	task automatic add_token(input logic [5:0] kind, input logic [15:0] start,
	                         input logic [15:0] len);
		lex_out_t t;
		t.token_kind = kind;
		t.text_start = start;
		t.text_length = len;
		t.position_overflow = ovf;
		t.last_result = 1'b0;
		step_toks = {step_toks, t};
	endtask

	task automatic bump_run();
		if (run_len != 16'hFFFF)
			run_len = run_len + 16'd1;
	endtask

	// Prefix is cleared at each word start, so padding matches the table.
	function automatic logic [5:0] classify_word();
		logic [5:0] kind;
		kind = K_IDENT;
		if (wlen <= WORD_KEEP) begin
			for (int k = 0; k < KW_COUNT; k++)
				if (wlen == KW_LEN[k] && prefix == KW_TEXT[k])
					kind = K_KW0 + 6'(k);
		end
		return kind;
	endfunction

	task automatic close_token();
		case (mode)
			SCAN_WORD: add_token(classify_word(), tok_start, run_len);
			SCAN_NUM:  add_token(K_NUMBER, tok_start, run_len);
			SCAN_STR:  add_token(K_STRING, tok_start, run_len);
			SCAN_GT:   add_token(K_GT, tok_start, 16'd1);
			SCAN_LT:   add_token(K_LT, tok_start, 16'd1);
			default: ;
		endcase
		mode = SCAN_IDLE;
	endtask

	task automatic open_token(input logic [7:0] c, input logic [15:0] off);
		tok_start = off;
		run_len = 16'd1;
		if (is_alpha(c) || c == "_") begin
			mode = SCAN_WORD;
			prefix = '0;
			prefix[63:56] = upper(c);
			wlen = 4'd1;
		end else if (is_num(c)) begin
			mode = SCAN_NUM;
		end else begin
			case (c)
				"'": begin
					mode = SCAN_STR;
					tok_start = (off < POS_LIMIT) ? off + 16'd1 : 16'(POS_LIMIT);
					run_len = '0;
				end
				"*": add_token(K_STAR, off, 16'd1);
				",": add_token(K_COMMA, off, 16'd1);
				"(": add_token(K_LPAREN, off, 16'd1);
				")": add_token(K_RPAREN, off, 16'd1);
				".": add_token(K_DOT, off, 16'd1);
				";": add_token(K_SEMI, off, 16'd1);
				"=": add_token(K_EQ, off, 16'd1);
				">": mode = SCAN_GT;
				"<": mode = SCAN_LT;
				"!": mode = SCAN_BANG;
				default: ;
			endcase
		end
	endtask

	task automatic scan_beat(input lex_in_t b);
		logic [15:0] off;
		logic [7:0]  c;
		logic        taken;
		lex_out_t    t;
		c = b.char_code;
		taken = 1'b0;
		step_toks.delete();
		if (b.has_char) begin
			// Saturate the offset once the position range is used up.
			if (next_pos <= POS_LIMIT) begin
				off = next_pos[15:0];
				next_pos = next_pos + 17'd1;
			end else begin
				off = 16'(POS_LIMIT);
				ovf = 1'b1;
			end
			case (mode)
				SCAN_WORD: if (is_alpha(c) || is_num(c) || c == "_") begin
					if (wlen < WORD_KEEP)
						prefix[63 - 8 * wlen -: 8] = upper(c);
					if (wlen <= WORD_KEEP)
						wlen = wlen + 4'd1;
					bump_run();
					taken = 1'b1;
				end
				SCAN_NUM: if (is_num(c)) begin
					bump_run();
					taken = 1'b1;
				end
				SCAN_STR: begin
					if (c == "'") begin
						add_token(K_STRING, tok_start, run_len);
						mode = SCAN_IDLE;
					end else begin
						bump_run();
					end
					taken = 1'b1;
				end
				SCAN_GT, SCAN_LT, SCAN_BANG: if (c == "=") begin
					add_token(mode == SCAN_GT ? K_GTE : (mode == SCAN_LT ? K_LTE : K_NEQ),
					          tok_start, 16'd2);
					mode = SCAN_IDLE;
					taken = 1'b1;
				end
				default: ;
			endcase
			if (!taken) begin
				close_token();
				open_token(c, off);
			end
		end
		if (b.is_last) begin
			close_token();
			add_token(K_END, (next_pos > POS_LIMIT) ? 16'(POS_LIMIT) : next_pos[15:0], 16'd0);
			clear_scan();
		end
		foreach (step_toks[i]) begin
			t = step_toks[i];
			t.last_result = (i == step_toks.size() - 1);
			tokens_due = {tokens_due, t};
		end
	endtask

	task automatic check_field(input string what, input int unsigned exp_val,
	                           input int unsigned act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val,
			         act_val);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			tokens_due.delete();
		end else begin
			// Take the byte beat first; its tokens cannot leave in this cycle.
			if (byte_valid && !byte_stall)
				scan_beat(byte_item);
			if (token_valid && !token_stall) begin
				checked++;
				if (tokens_due.size() == 0) begin
					$display("%0t: token with none due, expected nothing, actual kind %0d start %0d length %0d",
					         $time, token_item.token_kind, token_item.text_start,
					         token_item.text_length);
					fails++;
				end else begin
					want = tokens_due.pop_front();
					check_field("token_kind", want.token_kind, token_item.token_kind);
					check_field("text_start", want.text_start, token_item.text_start);
					check_field("text_length", want.text_length, token_item.text_length);
					check_field("position_overflow", want.position_overflow,
					            token_item.position_overflow);
					check_field("last_result", want.last_result, token_item.last_result);
				end
			end
		end
		fail_count <= fails;
		pending <= tokens_due.size();
		tokens_checked <= checked;
	end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SQL token lexer - testbench top
// Drives SQL text one byte beat at a time: a few directed texts, then random
// texts built from keywords, names, numbers, strings, operators and noise.
// Stalls the token side at random and once for a long stretch. The checker
// does all comparing.
// ---------------------------------------------------------------------------
module tb_top;
	import sqlt_pkg::*;

	localparam int RANDOM_ITEMS = 320;
	localparam int CALM_TAIL    = 60;
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	typedef enum int {PC_KEYWORD, PC_IDENT, PC_NUMBER, PC_STRING, PC_OPERATOR, PC_NOISE} piece_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     byte_valid = 1'b0;
	logic     byte_stall;
	lex_in_t  byte_item = '0;
	logic     token_valid;
	logic     token_stall = 1'b0;
	lex_out_t token_item;

	int fail_count;
	int pending;
	int tokens_checked;
	int items_sent = 0;
	int texts_sent = 0;
	int cycle_count = 0;
	bit quiet = 1'b0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	logic [7:0] text_q[$];

	string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
	string OP_CHARS   = "*,().;=<>!";

	sql_token_lexer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_item   (byte_item),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_item  (token_item)
	);

	lexer_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.byte_item      (byte_item),
		.token_valid    (token_valid),
		.token_stall    (token_stall),
		.token_item     (token_item),
		.fail_count     (fail_count),
		.pending        (pending),
		.tokens_checked (tokens_checked)
	);

	always #5 clk = ~clk;

	task automatic put_beat(input logic [7:0] c, input logic has, input logic last);
		lex_in_t b;
		b.char_code = c;
		b.has_char = has;
		b.is_last = last;
		if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= b;
		do @(posedge clk); while (byte_stall);
		items_sent++;
	endtask

	task automatic add_byte(input logic [7:0] b);
		text_q = {text_q, b};
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s.getc(i));
	endtask

	// End on the final byte, or with a separate beat that carries no byte.
	task automatic send_text(input bit end_on_byte);
		for (int i = 0; i < text_q.size(); i++)
			put_beat(text_q[i], 1'b1, end_on_byte && i == text_q.size() - 1);
		if (!end_on_byte || text_q.size() == 0)
			put_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		text_q.delete();
		texts_sent++;
	endtask

	function automatic logic [7:0] any_but_quote();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == "'");
		return b;
	endfunction

	task automatic build_text();
		int         n;
		int         k;
		int         len;
		piece_t     piece;
		logic [63:0] kw;
		logic [7:0] c;
		n = $urandom_range(1, 8);
		for (int t = 0; t < n; t++) begin
			piece = piece_t'($urandom_range(0, 5));
			case (piece)
				PC_KEYWORD: begin
					k = $urandom_range(0, KW_COUNT - 1);
					kw = KW_TEXT[k];
					for (int i = 0; i < int'(KW_LEN[k]); i++) begin
						c = kw[63 - 8 * i -: 8];
						add_byte($urandom_range(0, 1) ? c ^ 8'h20 : c);
					end
				end
				PC_IDENT: begin
					add_byte(WORD_CHARS.getc($urandom_range(0, 51)));
					if ($urandom_range(0, 3) == 0)
						text_q[text_q.size() - 1] = "_";
					len = $urandom_range(0, 11);
					repeat (len)
						add_byte(WORD_CHARS.getc($urandom_range(0, WORD_CHARS.len() - 1)));
				end
				PC_NUMBER: begin
					len = $urandom_range(1, 6);
					repeat (len)
						add_byte("0" + 8'($urandom_range(0, 9)));
				end
				PC_STRING: begin
					add_byte("'");
					len = $urandom_range(0, 6);
					repeat (len)
						add_byte(any_but_quote());
					// Leave the final string open now and then.
					if (t < n - 1 || $urandom_range(0, 3) != 0)
						add_byte("'");
				end
				PC_OPERATOR: begin
					c = OP_CHARS.getc($urandom_range(0, OP_CHARS.len() - 1));
					add_byte(c);
					if ((c == "<" || c == ">" || c == "!") && $urandom_range(0, 1))
						add_byte("=");
				end
				default: add_byte(8'($urandom_range(0, 255)));
			endcase
			case ($urandom_range(0, 3))
				1: add_byte(" ");
				2: add_byte("\n");
				3: add_byte("\t");
				default: ;
			endcase
		end
	endtask

	// Token-side stalls: random bursts, plus one long hold-off on request.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				token_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				token_stall <= 1'b0;
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				token_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				token_stall <= 1'b0;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d tokens still due", cycle_count, pending);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int rand_base;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed texts: two-byte operators, pending '>' and '<' at end,
		// lone '!', a beat with neither byte nor end, open string with a high byte.
		add_str("x<=9!=_;>");
		send_text(1'b0);
		put_beat(8'h5A, 1'b0, 1'b0);
		add_str("!a<");
		send_text(1'b1);
		add_str("From*(12).='");
		add_byte(8'hFF);
		send_text(1'b1);

		rand_base = items_sent;
		while (items_sent - rand_base < RANDOM_ITEMS) begin
			if (!hold_req && items_sent - rand_base >= 100) begin
				// Keep offering beats while the token side is held off.
				calm = 1'b1;
				hold_req = 1'b1;
				repeat (40) add_byte(",");
				send_text(1'b1);
				calm = 1'b0;
			end
			if (items_sent - rand_base >= RANDOM_ITEMS - CALM_TAIL)
				quiet = 1'b1;
			build_text();
			send_text(1'($urandom_range(0, 1)));
		end
		byte_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d byte beats in %0d texts and checked %0d tokens,", items_sent,
		         texts_sent, tokens_checked);
		$display("covering pending operators at end, open strings and a long token-side hold-off.");
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
